>>> hdl/intel_hex_record_writer_macros.svh
// Assertion macros used by the record writer controller.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef INTEL_HEX_RECORD_WRITER_MACROS_SVH
`define INTEL_HEX_RECORD_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IHW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IHW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ihw_pkg.sv
// Shared types, constants and character functions of the hex record writer.
// Depends on nothing.
package ihw_pkg;

   localparam int RECORD_BYTES_DEF = 16;
   localparam int FILL_W           = 5;
   localparam int CNT_W            = 5;
   localparam int END_CHARS        = 12;

   localparam logic [6:0] CHAR_COLON   = 7'h3A;
   localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLON,
      ST_HEAD,
      ST_DATA,
      ST_CSUM,
      ST_NEWLINE,
      ST_END
   } ctl_state_type;

   typedef enum logic [3:0] {
      SEL_COLON,
      SEL_LEN,
      SEL_ADDR_HI,
      SEL_ADDR_LO,
      SEL_ZERO,
      SEL_DATA,
      SEL_CSUM,
      SEL_NEWLINE,
      SEL_END
   } char_sel_type;

   typedef struct packed {
      logic               load;
      logic               emit;
      char_sel_type       sel;
      logic [CNT_W-1:0]   index;
      logic               last;
      logic               clear;
   } ctl_cmd_type;

   typedef struct packed {
      logic               close_now;
      logic               slot_free;
      logic [FILL_W-1:0]  fill;
   } dp_status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] wide;
      wide = {3'b000, nib};
      if (nib < 4'd10) return 7'h30 + wide;
      else             return 7'h37 + wide;
   endfunction

   // End-of-file record ":00000001FF\n"
   function automatic logic [6:0] end_char(input logic [3:0] idx);
      logic [6:0] ch;
      case (idx)
         4'd0:    ch = CHAR_COLON;
         4'd8:    ch = 7'h31;
         4'd9:    ch = 7'h46;
         4'd10:   ch = 7'h46;
         4'd11:   ch = CHAR_NEWLINE;
         default: ch = 7'h30;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/ihw_datapath.sv
// Datapath of the hex record writer: record buffer, fill count, start address,
// data sum, character formatter and output register. Depends on ihw_pkg.
module ihw_datapath #(
   parameter int RECORD_BYTES = ihw_pkg::RECORD_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ihw_pkg::ctl_cmd_type  cmd,
   output ihw_pkg::dp_status_type status,
   input  logic [15:0]           req_byte_address,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_present,
   input  logic                  req_final_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_text_char,
   output logic                  rsp_run_last
);
   import ihw_pkg::*;

   localparam int LIMIT_INT = (RECORD_BYTES < 1) ? 1 : ((RECORD_BYTES > 16) ? 16 : RECORD_BYTES);
   localparam logic [FILL_W-1:0] LIMIT = FILL_W'(LIMIT_INT);

   logic [7:0]        buf_ff [16];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       start_ff, start_in;
   logic [7:0]        sum_ff, sum_in;
   logic              valid_ff, valid_in;
   logic [6:0]        char_ff, char_in;
   logic              last_ff, last_in;

   logic [FILL_W-1:0] fill_new;
   logic [7:0]        cks;
   logic [7:0]        byte_val;
   logic [3:0]        nib;
   logic [6:0]        char_val;

   assign fill_new = req_present ? fill_ff + FILL_W'(1) : fill_ff;

   always_comb begin
      status.close_now = (fill_new != '0) &&
                         ((fill_new >= LIMIT) || !req_present || req_final_address);
      status.slot_free = !valid_ff || !rsp_stall;
      status.fill      = fill_ff;
   end

   assign cks = 8'h00 - (8'(fill_ff) + start_ff[15:8] + start_ff[7:0] + sum_ff);

   always_comb begin
      case (cmd.sel)
         SEL_LEN:     byte_val = 8'(fill_ff);
         SEL_ADDR_HI: byte_val = start_ff[15:8];
         SEL_ADDR_LO: byte_val = start_ff[7:0];
         SEL_DATA:    byte_val = buf_ff[cmd.index[4:1]];
         SEL_CSUM:    byte_val = cks;
         default:     byte_val = 8'h00;
      endcase
      nib = cmd.index[0] ? byte_val[3:0] : byte_val[7:4];
      case (cmd.sel)
         SEL_COLON:   char_val = CHAR_COLON;
         SEL_NEWLINE: char_val = CHAR_NEWLINE;
         SEL_END:     char_val = end_char(cmd.index[3:0]);
         default:     char_val = hex_char(nib);
      endcase
   end

   always_comb begin
      fill_in  = fill_ff;
      start_in = start_ff;
      sum_in   = sum_ff;
      if (cmd.load && req_present) begin
         fill_in = fill_new;
         if (fill_ff == '0) begin
            start_in = req_byte_address;
            sum_in   = req_data_byte;
         end else begin
            sum_in   = sum_ff + req_data_byte;
         end
      end
      if (cmd.clear) begin
         fill_in = '0;
      end
      valid_in = valid_ff && rsp_stall;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = char_val;
         last_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_present) begin
         buf_ff[fill_ff[3:0]] <= req_data_byte;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         start_ff <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         start_ff <= start_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_run_last  = last_ff;

endmodule

>>> hdl/ihw_ctrl.sv
// Controller of the hex record writer: walks the character sequence of a
// record and the end record. Depends on ihw_pkg and the assertion macros.
`include "intel_hex_record_writer_macros.svh"
module ihw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_final_address,
   output logic                   req_stall,
   input  ihw_pkg::dp_status_type status,
   output ihw_pkg::ctl_cmd_type   cmd
);
   import ihw_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             final_ff, final_in;
   logic [3:0]       last_byte;

   assign last_byte = 4'(status.fill - FILL_W'(1));

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      final_in  = final_ff;
      req_stall = (state_ff != ST_IDLE);
      cmd       = '0;
      cmd.sel   = SEL_COLON;
      cmd.index = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               final_in = req_final_address;
               cnt_in   = '0;
               if (status.close_now)      state_in = ST_COLON;
               else if (req_final_address) state_in = ST_END;
            end
         end
         ST_COLON: begin
            cmd.emit = status.slot_free;
            if (status.slot_free) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.emit = status.slot_free;
            case (cnt_ff[2:1])
               2'd0:    cmd.sel = SEL_LEN;
               2'd1:    cmd.sel = SEL_ADDR_HI;
               2'd2:    cmd.sel = SEL_ADDR_LO;
               default: cmd.sel = SEL_ZERO;
            endcase
            if (status.slot_free) begin
               if (cnt_ff == CNT_W'(7)) begin
                  cnt_in   = '0;
                  state_in = ST_DATA;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_DATA: begin
            cmd.emit = status.slot_free;
            cmd.sel  = SEL_DATA;
            if (status.slot_free) begin
               if (cnt_ff == {last_byte, 1'b1}) begin
                  cnt_in   = '0;
                  state_in = ST_CSUM;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_CSUM: begin
            cmd.emit = status.slot_free;
            cmd.sel  = SEL_CSUM;
            if (status.slot_free) begin
               if (cnt_ff[0]) begin
                  cnt_in   = '0;
                  state_in = ST_NEWLINE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_NEWLINE: begin
            cmd.emit  = status.slot_free;
            cmd.sel   = SEL_NEWLINE;
            cmd.last  = !final_ff;
            cmd.clear = status.slot_free;
            if (status.slot_free) begin
               cnt_in   = '0;
               state_in = final_ff ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            cmd.emit = status.slot_free;
            cmd.sel  = SEL_END;
            cmd.last = (cnt_ff == CNT_W'(END_CHARS - 1));
            if (status.slot_free) begin
               if (cmd.last) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         final_ff <= final_in;
      end
   end

   `IHW_ASSERT_NXT(a_close_starts_record, clock, reset, cmd.load && status.close_now, state_ff == ST_COLON, "closing transfer did not start a record")
   `IHW_ASSERT_IMP(a_data_has_fill, clock, reset, state_ff == ST_DATA, status.fill != '0, "data phase with empty record")
   `IHW_ASSERT_IMP(a_clear_on_emit, clock, reset, cmd.clear, cmd.emit && cmd.sel == SEL_NEWLINE, "record cleared without newline transfer")
   `IHW_ASSERT_NXT(a_last_leaves_empty, clock, reset, cmd.emit && cmd.last, status.fill == '0 && state_ff == ST_IDLE, "open record left after last character")

endmodule

>>> hdl/intel_hex_record_writer.sv
// Intel HEX record writer, top level: ties the controller to the datapath.
// Depends on ihw_pkg, ihw_ctrl and ihw_datapath.
//
// Usage:
//   req_ channel: one memory byte per transfer (address, data, present flag,
//   final-address flag), addresses ascending and consecutive. req_stall is
//   high while a record or the end record is being sent.
//   rsp_ channel: one ASCII character per transfer; rsp_run_last marks the
//   last character caused by one input transfer.
// Throughput: a byte that leaves its record open is accepted without a stall. A
//   byte that closes a record holds req_stall high while the colon, header,
//   data and checksum digits and newline are sent, and the end record too when
//   it carries the final address; one character leaves per cycle unless
//   rsp_stall holds it, paced by the controller's character sequencer.
// Stall: while rsp_stall is high the output register holds its valid character
//   and the sequencer waits; no character is lost or repeated.
// Reset: synchronous; clears the open record, the output valid flag and the
//   sequencer. The record buffer and the output character are not cleared.
module intel_hex_record_writer #(
   parameter int RECORD_BYTES = ihw_pkg::RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_byte_address,
   input  logic [7:0]  req_data_byte,
   input  logic        req_present,
   input  logic        req_final_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_run_last
);
   import ihw_pkg::*;

   // Command and status between the sequencer and the datapath
   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence each record: colon, header digits, data digits, checksum, newline; then the end record
   ihw_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_final_address (req_final_address),
      .req_stall         (req_stall),
      .status            (status),
      .cmd               (cmd)
   );

   // Hold the open record and format each character into the output register
   ihw_datapath #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_byte_address  (req_byte_address),
      .req_data_byte     (req_data_byte),
      .req_present       (req_present),
      .req_final_address (req_final_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_text_char     (rsp_text_char),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
